### rtl/sai_pkg.sv
`timescale 1ns / 1ps
// Package for the shift array block: size constants, command codes and the
// command and status structures between controller and datapath.
// It has no dependencies.
package sai_pkg;

   localparam int CAPACITY   = 16;
   localparam int CELL_IDX_W = $clog2(CAPACITY);
   localparam int LEN_W      = $clog2(CAPACITY + 1);
   localparam int DATA_W     = 32;
   localparam int CMD_W      = 3;
   localparam int POS_W      = 4;
   localparam int CSR_W      = 5;

   localparam logic signed [DATA_W-1:0] MIN_START = 32'sd10000;

   localparam logic [CMD_W-1:0] CMD_READ   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_MIN    = 3'd5;

   typedef enum logic [1:0] {
      OUT_CELL  = 2'd0,
      OUT_DATA  = 2'd1,
      OUT_ERROR = 2'd2,
      OUT_MIN   = 2'd3
   } out_sel_type;

   typedef struct packed {
      logic        do_insert;
      logic        do_delete;
      logic        do_write;
      logic        idx_from_count;
      logic        count_clear;
      logic        count_step;
      logic        min_clear;
      logic        min_step;
      logic        out_load;
      out_sel_type out_sel;
      logic        out_last;
   } dp_cmd_type;

   typedef struct packed {
      logic pos_ok;
      logic count_last;
      logic slot_free;
   } dp_status_type;

endpackage

### rtl/sai_datapath.sv
`timescale 1ns / 1ps
// Datapath of the shift array: the cell registers, the length register,
// the scan counter, the running minimum and the result register.
// Depends on sai_pkg.
module sai_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [sai_pkg::CSR_W-1:0]    csr_write_data,
   input  logic [sai_pkg::POS_W-1:0]    req_position,
   input  logic signed [sai_pkg::DATA_W-1:0] req_data_in,
   input  logic                         rsp_stall,
   output logic                         rsp_valid,
   output logic signed [sai_pkg::DATA_W-1:0] rsp_data_out,
   output logic                         rsp_last_of_run,
   output logic                         rsp_index_error,
   input  sai_pkg::dp_cmd_type          cmd,
   output sai_pkg::dp_status_type       status
);
   import sai_pkg::*;

   logic signed [DATA_W-1:0] cells_ff [CAPACITY];
   logic signed [DATA_W-1:0] cells_in [CAPACITY];
   logic [CSR_W-1:0]         length_ff;
   logic [LEN_W-1:0]         len;
   logic [CELL_IDX_W-1:0]    count_ff;
   logic [CELL_IDX_W-1:0]    count_in;
   logic signed [DATA_W-1:0] min_ff;
   logic signed [DATA_W-1:0] min_in;
   logic [CELL_IDX_W-1:0]    rd_idx;
   logic signed [DATA_W-1:0] cell_rd;
   logic                     valid_ff;
   logic                     valid_in;
   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;
   logic                     last_ff;
   logic                     last_in;
   logic                     error_ff;
   logic                     error_in;
   logic                     slot_free;

   // A length of zero acts as one and a length beyond the array as its size.
   always_comb begin
      if (length_ff == '0) begin
         len = LEN_W'(1);
      end else if (32'(length_ff) > CAPACITY) begin
         len = LEN_W'(CAPACITY);
      end else begin
         len = LEN_W'(length_ff);
      end
   end

   assign rd_idx  = cmd.idx_from_count ? count_ff : CELL_IDX_W'(req_position);
   assign cell_rd = cells_ff[rd_idx];

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cells_in[i] = cells_ff[i];
         if (cmd.do_insert) begin
            if (i == 32'(req_position)) begin
               cells_in[i] = req_data_in;
            end else if (i > 32'(req_position) && i < 32'(len)) begin
               cells_in[i] = cells_ff[(i + CAPACITY - 1) % CAPACITY];
            end
         end else if (cmd.do_delete) begin
            if (i == 32'(len) - 1) begin
               cells_in[i] = '0;
            end else if (i >= 32'(req_position) && i < 32'(len) - 1) begin
               cells_in[i] = cells_ff[(i + 1) % CAPACITY];
            end
         end else if (cmd.do_write) begin
            if (i == 32'(req_position)) begin
               cells_in[i] = req_data_in;
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.count_clear) begin
         count_in = '0;
      end else if (cmd.count_step) begin
         count_in = count_ff + CELL_IDX_W'(1);
      end
   end

   always_comb begin
      min_in = min_ff;
      if (cmd.min_clear) begin
         min_in = MIN_START;
      end else if (cmd.min_step && cell_rd < min_ff) begin
         min_in = cell_rd;
      end
   end

   assign slot_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      data_in  = data_ff;
      last_in  = last_ff;
      error_in = error_ff;
      if (cmd.out_load) begin
         valid_in = 1'b1;
         last_in  = cmd.out_last;
         error_in = 1'b0;
         unique case (cmd.out_sel)
            OUT_CELL: begin
               data_in = cell_rd;
            end
            OUT_DATA: begin
               data_in = req_data_in;
            end
            OUT_ERROR: begin
               data_in  = '0;
               last_in  = 1'b1;
               error_in = 1'b1;
            end
            OUT_MIN: begin
               data_in = min_ff;
            end
            default: begin
               data_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CAPACITY; i++) begin
            cells_ff[i] <= '0;
         end
         length_ff <= CSR_W'(16);
         count_ff  <= '0;
         valid_ff  <= 1'b0;
      end else begin
         for (int i = 0; i < CAPACITY; i++) begin
            cells_ff[i] <= cells_in[i];
         end
         if (csr_write_enable) begin
            length_ff <= csr_write_data;
         end
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      min_ff   <= min_in;
      data_ff  <= data_in;
      last_ff  <= last_in;
      error_ff <= error_in;
   end

   assign status.pos_ok     = 32'(req_position) < 32'(len);
   assign status.count_last = 32'(count_ff) == 32'(len) - 1;
   assign status.slot_free  = slot_free;

   assign rsp_valid       = valid_ff;
   assign rsp_data_out    = data_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_index_error = error_ff;

endmodule

### rtl/sai_controller.sv
`timescale 1ns / 1ps
// Controller of the shift array: decodes each command and sequences the
// scans for dump and minimum. Depends on sai_pkg.
module sai_controller (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [sai_pkg::CMD_W-1:0]   req_command,
   output logic                        req_stall,
   output sai_pkg::dp_cmd_type         cmd,
   input  sai_pkg::dp_status_type      status
);
   import sai_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_DUMP    = 4'b0010,
      ST_MIN     = 4'b0100,
      ST_MIN_OUT = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = !(state_ff == ST_IDLE && status.slot_free);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.out_sel = OUT_CELL;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  CMD_READ: begin
                     cmd.out_load = 1'b1;
                     cmd.out_last = 1'b1;
                     cmd.out_sel  = status.pos_ok ? OUT_CELL : OUT_ERROR;
                  end
                  CMD_INSERT: begin
                     cmd.do_insert = status.pos_ok;
                     cmd.out_load  = !status.pos_ok;
                     cmd.out_sel   = OUT_ERROR;
                  end
                  CMD_DELETE: begin
                     cmd.do_delete = status.pos_ok;
                     cmd.out_load  = !status.pos_ok;
                     cmd.out_sel   = OUT_ERROR;
                  end
                  CMD_WRITE: begin
                     cmd.do_write = status.pos_ok;
                     cmd.out_load = 1'b1;
                     cmd.out_last = 1'b1;
                     cmd.out_sel  = status.pos_ok ? OUT_DATA : OUT_ERROR;
                  end
                  CMD_DUMP: begin
                     cmd.count_clear = 1'b1;
                     state_in        = ST_DUMP;
                  end
                  CMD_MIN: begin
                     cmd.count_clear = 1'b1;
                     cmd.min_clear   = 1'b1;
                     state_in        = ST_MIN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_DUMP: begin
            cmd.idx_from_count = 1'b1;
            if (status.slot_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_sel    = OUT_CELL;
               cmd.out_last   = status.count_last;
               cmd.count_step = 1'b1;
               if (status.count_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_MIN: begin
            cmd.idx_from_count = 1'b1;
            cmd.min_step       = 1'b1;
            cmd.count_step     = 1'b1;
            if (status.count_last) begin
               state_in = ST_MIN_OUT;
            end
         end
         ST_MIN_OUT: begin
            if (status.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_MIN;
               cmd.out_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/shift_array_insert_delete_top.sv
`timescale 1ns / 1ps
// Top level of the shift array with insert and delete.
// Depends on sai_pkg, sai_controller and sai_datapath.
//
// The block holds sixteen signed 32-bit cells. A request beat carries a
// command (read, insert, delete, write, dump or minimum), a position and a
// value. Each response beat carries a value, a last-of-run flag and an
// index error flag. The csr port writes the active length.
// Read, write, insert, delete and errors complete in the accepting cycle;
// a read, write or error response is registered and appears in the cycle
// after acceptance. A dump gives one response beat per active cell, one
// per cycle while the receiver keeps up. A minimum scans one cell a cycle
// through the shared read port, then loads the minimum into the response
// register once it can take a beat. Any other command is taken without
// effect. A new request is taken whenever the block is not scanning and
// the response register is empty or being emptied in the same cycle.
// Reset clears every cell to zero and sets the active length to sixteen.
// When the receiver stalls, the response beat is held and the request
// channel stalls until the response register can take the next beat.
module shift_array_insert_delete_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [sai_pkg::CMD_W-1:0]         req_command,
   input  logic [sai_pkg::POS_W-1:0]         req_position,
   input  logic signed [sai_pkg::DATA_W-1:0] req_data_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [sai_pkg::DATA_W-1:0] rsp_data_out,
   output logic                              rsp_last_of_run,
   output logic                              rsp_index_error,
   input  logic                              csr_write_enable,
   input  logic [sai_pkg::CSR_W-1:0]         csr_write_data
);
   import sai_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   sai_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .cmd         (cmd),
      .status      (status)
   );

   sai_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_position     (req_position),
      .req_data_in      (req_data_in),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_data_out     (rsp_data_out),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_index_error  (rsp_index_error),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
